@@ design/fdt_pkg.sv @@
// Shared types, constants and helpers for the fixed-point to decimal text formatter.
package fdt_pkg;

   // Field widths.
   localparam int WORD_WIDTH  = 32;
   localparam int HALF_WIDTH  = 16;
   localparam int DIGIT_WIDTH = 4;
   localparam int CHAR_WIDTH  = 8;

   // Layout of the text.
   localparam int WHOLE_DIGITS_DEF = 5;
   localparam int FRACTION_DIGITS  = 5;

   // A 16-bit whole part has at most five digits, and there are five fraction weights.
   // Each digit stage handles one of each.
   localparam int DIGIT_COUNT = 5;

   // Reciprocal of ten. It is exact for every 16-bit dividend.
   localparam int RECIP_TEN   = 52429;
   localparam int RECIP_SHIFT = 19;
   localparam int TEN         = 10;
   localparam int MAX_DIGIT   = 9;

   // ASCII codes.
   localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;

   typedef logic [DIGIT_WIDTH-1:0] digit_type;

   // Data that travels down the digit pipeline.
   typedef struct packed {
      logic                                neg;
      logic [HALF_WIDTH-1:0]               whole;
      logic [HALF_WIDTH-1:0]               frac;
      logic [DIGIT_COUNT-1:0][DIGIT_WIDTH-1:0] wdig;
      logic [DIGIT_COUNT-1:0][DIGIT_WIDTH-1:0] fdig;
   } pipe_type;

   // Weight of each fraction place.
   function automatic logic [HALF_WIDTH-1:0] frac_weight(input int idx);
      logic [HALF_WIDTH-1:0] w;
      unique case (idx)
         0:       w = 16'd6553;
         1:       w = 16'd655;
         2:       w = 16'd65;
         3:       w = 16'd7;
         default: w = 16'd1;
      endcase
      return w;
   endfunction

endpackage

@@ design/fdt_digit_stage.sv @@
// One pipeline stage that extracts one whole digit and one fraction digit.
module fdt_digit_stage #(
   parameter int IDX = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_stall,
   input  fdt_pkg::pipe_type in_data,
   output logic             out_valid,
   input  logic             out_stall,
   output fdt_pkg::pipe_type out_data
);
   import fdt_pkg::*;

   localparam logic [HALF_WIDTH-1:0] WEIGHT = frac_weight(IDX);

   logic [WORD_WIDTH-1:0] prod;
   logic [HALF_WIDTH-1:0] quot10;
   logic [HALF_WIDTH-1:0] tenfold;
   logic [HALF_WIDTH-1:0] wrem;
   logic [DIGIT_WIDTH-1:0] fq;
   logic [HALF_WIDTH-1:0] fsub;
   logic                  advance;
   logic                  valid_ff;
   pipe_type              data_ff;
   pipe_type              data_in;

   // Whole part: divide by ten with a reciprocal multiply, keep the remainder as the digit.
   always_comb begin
      prod    = WORD_WIDTH'(in_data.whole) * WORD_WIDTH'(RECIP_TEN);
      quot10  = HALF_WIDTH'(prod >> RECIP_SHIFT);
      tenfold = {quot10[HALF_WIDTH-4:0], 3'b000} + {quot10[HALF_WIDTH-2:0], 1'b0};
      wrem    = in_data.whole - tenfold;
   end

   // Fraction part: compare against the weight times one to nine, the quotient clamps at nine.
   always_comb begin
      fq   = '0;
      fsub = '0;
      for (int k = 1; k <= MAX_DIGIT; k++) begin
         if (in_data.frac >= HALF_WIDTH'(k * int'(WEIGHT))) begin
            fq   = DIGIT_WIDTH'(k);
            fsub = HALF_WIDTH'(k * int'(WEIGHT));
         end
      end
   end

   // Next contents of the stage register.
   always_comb begin
      data_in           = in_data;
      data_in.whole     = quot10;
      data_in.frac      = in_data.frac - fsub;
      data_in.wdig[IDX] = wrem[DIGIT_WIDTH-1:0];
      data_in.fdig[IDX] = fq;
   end

   // The stage takes new data whenever it is empty or its content moves on.
   assign advance  = !valid_ff || !out_stall;
   assign in_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // The reciprocal divide must always leave a decimal digit.
   assert property (@(posedge clock) disable iff (reset)
      out_valid |-> out_data.wdig[IDX] <= DIGIT_WIDTH'(MAX_DIGIT))
      else $error("whole digit out of range");

   // The carried remainder is below the weight unless the digit was clamped.
   assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_data.frac < WEIGHT) || (out_data.fdig[IDX] == DIGIT_WIDTH'(MAX_DIGIT)))
      else $error("fraction remainder not reduced");

endmodule

@@ design/fdt_format.sv @@
// Pipeline stage that lays out the digits, sign and point as ASCII text.
module fdt_format #(
   parameter int WHOLE_DIGITS = fdt_pkg::WHOLE_DIGITS_DEF,
   parameter int TEXT_LEN     = WHOLE_DIGITS + fdt_pkg::FRACTION_DIGITS + 2
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   output logic                                     in_stall,
   input  fdt_pkg::pipe_type                        in_data,
   output logic                                     out_valid,
   input  logic                                     out_stall,
   output logic [TEXT_LEN-1:0][fdt_pkg::CHAR_WIDTH-1:0] out_text
);
   import fdt_pkg::*;

   localparam int NW = $clog2(DIGIT_COUNT + 1);

   logic [NW-1:0]                       ndig;
   logic                                sign_field;
   logic                                advance;
   logic                                valid_ff;
   logic [TEXT_LEN-1:0][CHAR_WIDTH-1:0] text_ff;
   logic [TEXT_LEN-1:0][CHAR_WIDTH-1:0] text_in;

   // Number of significant whole digits, at least one so that zero shows as '0'.
   always_comb begin
      ndig = NW'(1);
      for (int j = 1; j < DIGIT_COUNT; j++) begin
         if (in_data.wdig[j] != '0) begin
            ndig = NW'(j + 1);
         end
      end
   end

   // The sign sits just left of the digits when a padding position other than the
   // leftmost one is free; otherwise it takes the lead place.
   assign sign_field = in_data.neg && (int'(ndig) + 2 <= WHOLE_DIGITS);

   always_comb begin
      text_in    = '0;
      text_in[0] = (in_data.neg && !sign_field) ? CHAR_MINUS : CHAR_SPACE;
      // Whole positions, counted from the right: digits, sign, then padding.
      for (int j = 0; j < WHOLE_DIGITS; j++) begin
         text_in[WHOLE_DIGITS - j] = CHAR_SPACE;
         if (sign_field && (j == int'(ndig))) begin
            text_in[WHOLE_DIGITS - j] = CHAR_MINUS;
         end
      end
      for (int j = 0; j < DIGIT_COUNT; j++) begin
         if (j < int'(ndig)) begin
            text_in[WHOLE_DIGITS - j] = CHAR_ZERO + CHAR_WIDTH'(in_data.wdig[j]);
         end
      end
      text_in[WHOLE_DIGITS + 1] = CHAR_DOT;
      for (int i = 0; i < FRACTION_DIGITS; i++) begin
         text_in[WHOLE_DIGITS + 2 + i] = CHAR_ZERO + CHAR_WIDTH'(in_data.fdig[i]);
      end
   end

   assign advance  = !valid_ff || !out_stall;
   assign in_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         text_ff <= text_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_text  = text_ff;

endmodule

@@ design/fdt_serializer.sv @@
// Output shift register that sends the formatted text one character per cycle while not stalled.
module fdt_serializer #(
   parameter int TEXT_LEN = fdt_pkg::WHOLE_DIGITS_DEF + fdt_pkg::FRACTION_DIGITS + 2
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   output logic                                     in_stall,
   input  logic [TEXT_LEN-1:0][fdt_pkg::CHAR_WIDTH-1:0] in_text,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [fdt_pkg::CHAR_WIDTH-1:0]           rsp_character,
   output logic                                     rsp_last
);
   import fdt_pkg::*;

   localparam int CW        = $clog2(TEXT_LEN + 1);
   localparam int TEXT_BITS = TEXT_LEN * CHAR_WIDTH;

   logic [CW-1:0]                       count_ff;
   logic [CW-1:0]                       count_in;
   logic [TEXT_LEN-1:0][CHAR_WIDTH-1:0] text_ff;
   logic [TEXT_LEN-1:0][CHAR_WIDTH-1:0] text_in;
   logic                                take;
   logic                                load;

   assign rsp_valid     = (count_ff != '0);
   assign rsp_last      = (count_ff == CW'(1));
   assign rsp_character = text_ff[0];

   // A new text loads when the register is empty or its last character leaves now.
   assign take     = rsp_valid && !rsp_stall;
   assign in_stall = rsp_valid && !(take && rsp_last);
   assign load     = in_valid && !in_stall;

   always_comb begin
      count_in = count_ff;
      text_in  = text_ff;
      if (load) begin
         count_in = CW'(TEXT_LEN);
         text_in  = in_text;
      end else if (take) begin
         count_in = count_ff - CW'(1);
         text_in  = TEXT_BITS'(text_ff >> CHAR_WIDTH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      text_ff <= text_in;
   end

   // A loaded text always starts with the full character count.
   assert property (@(posedge clock) disable iff (reset)
      load |=> count_ff == CW'(TEXT_LEN))
      else $error("text loaded with wrong count");

   // A text is never cut short: after any character but the last, another follows.
   assert property (@(posedge clock) disable iff (reset)
      take && !rsp_last |=> rsp_valid)
      else $error("text ended early");

   // The count never runs past the text length.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TEXT_LEN))
      else $error("character count overflow");

endmodule

@@ design/fix16_to_decimal_text.sv @@
// A request passes the input, digit stage and format registers before its first character.
// Each request yields WHOLE_DIGITS + 7 characters (12 by default); the last one carries rsp_last.
// The output shift register holds one text at a time and sets the request rate; it loads
// the next text in the cycle its last character is taken.
// Reset is synchronous and active high; it clears the stage valid bits and the character count.
module fix16_to_decimal_text #(
   parameter int WHOLE_DIGITS = fdt_pkg::WHOLE_DIGITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [fdt_pkg::WORD_WIDTH-1:0] req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [fdt_pkg::CHAR_WIDTH-1:0] rsp_character,
   output logic                           rsp_last
);
   import fdt_pkg::*;

   localparam int TEXT_LEN = WHOLE_DIGITS + FRACTION_DIGITS + 2;

   pipe_type                            stage_data  [DIGIT_COUNT+1];
   logic [DIGIT_COUNT:0]                stage_valid;
   logic [DIGIT_COUNT:0]                stage_stall;
   logic                                in_valid_ff;
   pipe_type                            in_data_ff;
   pipe_type                            in_data_in;
   logic [WORD_WIDTH-1:0]               mag;
   logic                                in_advance;
   logic                                fmt_valid;
   logic                                fmt_stall;
   logic [TEXT_LEN-1:0][CHAR_WIDTH-1:0] fmt_text;

   // Input stage: take the magnitude and split it into whole and fraction parts.
   always_comb begin
      mag              = req_value[WORD_WIDTH-1] ? (WORD_WIDTH'(0) - WORD_WIDTH'(req_value))
                                                 : WORD_WIDTH'(req_value);
      in_data_in       = '0;
      in_data_in.neg   = req_value[WORD_WIDTH-1];
      in_data_in.whole = mag[WORD_WIDTH-1:HALF_WIDTH];
      in_data_in.frac  = mag[HALF_WIDTH-1:0];
   end

   assign in_advance = !in_valid_ff || !stage_stall[0];
   assign req_stall  = !in_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_advance) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_advance) begin
         in_data_ff <= in_data_in;
      end
   end

   assign stage_valid[0] = in_valid_ff;
   assign stage_data[0]  = in_data_ff;

   // Digit pipeline: each stage produces one whole digit and one fraction digit.
   for (genvar g = 0; g < DIGIT_COUNT; g++) begin : g_digit
      fdt_digit_stage #(
         .IDX(g)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[g]),
         .in_stall  (stage_stall[g]),
         .in_data   (stage_data[g]),
         .out_valid (stage_valid[g+1]),
         .out_stall (stage_stall[g+1]),
         .out_data  (stage_data[g+1])
      );
   end

   fdt_format #(
      .WHOLE_DIGITS (WHOLE_DIGITS),
      .TEXT_LEN     (TEXT_LEN)
   ) u_format (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid[DIGIT_COUNT]),
      .in_stall  (stage_stall[DIGIT_COUNT]),
      .in_data   (stage_data[DIGIT_COUNT]),
      .out_valid (fmt_valid),
      .out_stall (fmt_stall),
      .out_text  (fmt_text)
   );

   fdt_serializer #(
      .TEXT_LEN (TEXT_LEN)
   ) u_serializer (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (fmt_valid),
      .in_stall      (fmt_stall),
      .in_text       (fmt_text),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule
